// ----- rtl/core/prime_range_sum_top_defines.svh -----
// Assertion macros shared by the prime range sum RTL.
`ifndef PRIME_RANGE_SUM_TOP_DEFINES_SVH
`define PRIME_RANGE_SUM_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk, masked during rst
`define PRS_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, masked during rst
`define PRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/prs_pkg.sv -----
// Package with result types and status codes of the prime range sum block.
package prs_pkg;

  localparam int SUM_WIDTH    = 28;
  localparam int STATUS_WIDTH = 2;
  localparam int OUT_DATA_W   = ((SUM_WIDTH + 7) / 8) * 8;

  typedef logic [SUM_WIDTH-1:0]    sum_t;
  typedef logic [STATUS_WIDTH-1:0] status_t;

  // Status codes
  localparam status_t STATUS_OK          = 2'd0;
  localparam status_t STATUS_A_NOT_POS   = 2'd1;
  localparam status_t STATUS_A_NOT_BELOW = 2'd2;

  localparam sum_t SUM_MAX = '1;

endpackage

// ----- rtl/core/prime_range_sum_top.sv -----
// Sum of the primes strictly between two bounds, by trial division.
//
// A request carries bounds A and B; the single result carries the sum of all
// primes p with A < p < B (saturating at 2^28-1) and a status: bit 0 set when
// A is not positive, bit 1 set when A is not below B, in which case the sum is
// zero. One request is worked on at a time and s_axis_tready is low meanwhile.
// Every candidate n is tested against divisors d = 2, 3, ... while d*d <= n,
// stopping at the first divisor that leaves no remainder; each test runs
// through one bit-serial remainder unit (ST_TEST, then ST_DIV, then ST_CHECK).
// Invalid bounds skip the search and go straight to ST_FINISH.
// The finished result sits in an output register, so the next request may be
// taken while it waits.
`include "prime_range_sum_top_defines.svh"

module prime_range_sum_top #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  // request: lower_bound [VALUE_WIDTH-1:0], upper_bound above it, zero pad
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  logic [((2*VALUE_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
  // result: prime_sum [27:0], zero pad [31:28]
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  output logic [prs_pkg::OUT_DATA_W-1:0]           m_axis_tdata,
  // result: status [1:0]
  output prs_pkg::status_t                         m_axis_tuser
);
  import prs_pkg::*;

  localparam int CNT_W = $clog2(VALUE_WIDTH);

  // Sequencer codes
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CAND   = 3'd1;
  localparam logic [2:0] ST_TEST   = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_CHECK  = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0]             state;
  logic [VALUE_WIDTH-1:0] candidate;
  logic [VALUE_WIDTH-1:0] upper;
  logic [VALUE_WIDTH-1:0] divisor;
  logic [VALUE_WIDTH:0]   dsq;        // divisor squared, kept by increments
  logic [VALUE_WIDTH-1:0] rem;        // partial remainder
  logic [VALUE_WIDTH-1:0] dividend;   // candidate, shifted out MSB first
  logic [CNT_W-1:0]       bit_cnt;
  sum_t                   running_sum;
  status_t                status;

  // Request fields and bound checks
  logic signed [VALUE_WIDTH-1:0] in_lower;
  logic signed [VALUE_WIDTH-1:0] in_upper;
  status_t                       in_status;

  assign in_lower = $signed(s_axis_tdata[VALUE_WIDTH-1:0]);
  assign in_upper = $signed(s_axis_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH]);

  always_comb begin
    in_status = STATUS_OK;
    if (in_lower <= $signed({VALUE_WIDTH{1'b0}})) begin
      in_status = in_status | STATUS_A_NOT_POS;
    end
    if (in_lower >= in_upper) begin
      in_status = in_status | STATUS_A_NOT_BELOW;
    end
  end

  // Shared remainder step: shift in one dividend bit, subtract if it fits
  logic [VALUE_WIDTH:0] rem_shift;
  logic [VALUE_WIDTH:0] rem_sub;
  logic                 rem_fits;

  assign rem_shift = {rem, dividend[VALUE_WIDTH-1]};
  assign rem_sub   = rem_shift - {1'b0, divisor};
  assign rem_fits  = rem_shift >= {1'b0, divisor};

  // Saturating accumulate of a prime
  logic [SUM_WIDTH:0] sum_ext;
  assign sum_ext = {1'b0, running_sum}
                 + {{(SUM_WIDTH + 1 - VALUE_WIDTH){1'b0}}, candidate};

  logic out_free;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      candidate   <= '0;
      divisor     <= '0;
      running_sum <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            status      <= in_status;
            running_sum <= '0;
            divisor     <= '0;
            upper       <= in_upper;
            if (in_status != STATUS_OK) begin
              candidate <= '0;
              state     <= ST_FINISH;
            end else begin
              // A is positive here, so every candidate is at least 2
              candidate <= in_lower + 1'b1;
              state     <= ST_CAND;
            end
          end
        end
        ST_CAND: begin
          if (candidate >= upper) begin
            state <= ST_FINISH;
          end else begin
            divisor <= VALUE_WIDTH'(2);
            dsq     <= (VALUE_WIDTH + 1)'(4);
            state   <= ST_TEST;
          end
        end
        ST_TEST: begin
          if (dsq > {1'b0, candidate}) begin
            // no divisor up to the square root: prime
            running_sum <= sum_ext[SUM_WIDTH] ? SUM_MAX : sum_ext[SUM_WIDTH-1:0];
            candidate   <= candidate + 1'b1;
            state       <= ST_CAND;
          end else begin
            rem      <= '0;
            dividend <= candidate;
            bit_cnt  <= CNT_W'(VALUE_WIDTH - 1);
            state    <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem      <= rem_fits ? rem_sub[VALUE_WIDTH-1:0] : rem_shift[VALUE_WIDTH-1:0];
          dividend <= {dividend[VALUE_WIDTH-2:0], 1'b0};
          if (bit_cnt == '0) begin
            state <= ST_CHECK;
          end else begin
            bit_cnt <= bit_cnt - 1'b1;
          end
        end
        ST_CHECK: begin
          if (rem == '0) begin
            candidate <= candidate + 1'b1;
            state     <= ST_CAND;
          end else begin
            dsq     <= dsq + {divisor, 1'b1};
            divisor <= divisor + 1'b1;
            state   <= ST_TEST;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      m_axis_tvalid <= 1'b1;
      m_axis_tdata  <= {{(OUT_DATA_W - SUM_WIDTH){1'b0}}, running_sum};
      m_axis_tuser  <= status;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Checks
  logic [2*VALUE_WIDTH-1:0] div_sq_chk;
  assign div_sq_chk = (2*VALUE_WIDTH)'(divisor) * (2*VALUE_WIDTH)'(divisor);

  `PRS_ASSERT_IMPLIES(a_rem_below_div, state == ST_DIV, rem < divisor, "remainder not below divisor")
  `PRS_ASSERT_IMPLIES(a_dsq_track, state == ST_TEST, (2*VALUE_WIDTH)'(dsq) == div_sq_chk, "divisor square drifted")
  `PRS_ASSERT_NEXT(a_finish_out, state == ST_FINISH && out_free, m_axis_tvalid && state == ST_IDLE, "result not presented")
  `PRS_ASSERT_IMPLIES(a_bad_zero, m_axis_tvalid && m_axis_tuser != STATUS_OK, m_axis_tdata == '0, "invalid bounds gave a sum")

endmodule

// ----- verif/tb_prime_range_sum_top.sv -----
// Self-checking testbench for the prime range sum block: queued requests, predicted sums, stalls.
`timescale 1ns / 100ps

module tb_prime_range_sum_top;
  import prs_pkg::*;

  localparam int VALUE_WIDTH = 16;
  localparam int IN_DATA_W   = ((2*VALUE_WIDTH+7)/8)*8;
  // longest quiet stretch: a near-top range of prime-heavy candidates, times several
  localparam int QUIET_LIMIT = 400000;
  localparam int TAIL_CYCLES = 100;
  localparam int RAND_PER_PHASE = 25;

  typedef logic signed [VALUE_WIDTH-1:0] bound_t;

  typedef struct {
    bound_t lo;
    bound_t hi;
    int     phase;
    bit     drain;   // hold this request back until every result is in
  } bounds_req_t;

  typedef struct {
    sum_t    prime_sum;
    status_t status;
  } range_result_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  status_t                m_axis_tuser;

  bounds_req_t   pending_q[$];
  range_result_t expected_sums_q[$];
  bounds_req_t   live_req;
  int            queued_count   = 0;
  int            accepted_count = 0;
  int            result_count   = 0;
  int            err_count      = 0;
  int            quiet_cycles   = 0;
  logic [1:0]    rx_phase       = 2'd0;

  // per phase: no idling, sender idle, receiver stalling, both
  int send_idle_pct [4] = '{0, 65, 0, 28};
  int recv_stall_pct[4] = '{0, 0, 65, 28};

  prime_range_sum_top #(.VALUE_WIDTH(VALUE_WIDTH)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sum of primes strictly between the bounds, trial division while d*d <= n
  function automatic range_result_t predict_prime_sum(bound_t lo, bound_t hi);
    range_result_t r;
    int     a;
    int     b;
    int     n;
    int     d;
    bit     is_prime;
    longint acc;
    a = lo;
    b = hi;
    r.status = STATUS_OK;
    if (a <= 0)
      r.status = r.status | STATUS_A_NOT_POS;
    if (a >= b)
      r.status = r.status | STATUS_A_NOT_BELOW;
    acc = 0;
    if (r.status == STATUS_OK) begin
      for (n = a + 1; n < b; n++) begin
        is_prime = (n >= 2);
        for (d = 2; is_prime && d * d <= n; d++)
          if (n % d == 0)
            is_prime = 1'b0;
        if (is_prime) begin
          acc = acc + n;
          if (acc > SUM_MAX)
            acc = SUM_MAX;
        end
      end
    end
    r.prime_sum = acc[SUM_WIDTH-1:0];
    return r;
  endfunction

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic add_bounds(int a, int b, int phase, bit drain);
    bounds_req_t r;
    r.lo    = a[VALUE_WIDTH-1:0];
    r.hi    = b[VALUE_WIDTH-1:0];
    r.phase = phase;
    r.drain = drain;
    pending_q.push_back(r);
    queued_count++;
  endtask

  // Driver: present queued requests, predict each one on acceptance
  always @(posedge clk) begin
    bit accepted;
    accepted = 1'b0;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_sums_q.push_back(predict_prime_sum(live_req.lo, live_req.hi));
        accepted_count++;
        accepted = 1'b1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_q.size() > 0 &&
            $urandom_range(99) >= send_idle_pct[pending_q[0].phase] &&
            !(pending_q[0].drain && (accepted || expected_sums_q.size() != 0))) begin
          live_req = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {live_req.hi, live_req.lo};
          rx_phase      <= live_req.phase[1:0];
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, compare each result with the oldest prediction
  always @(posedge clk) begin
    range_result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_sums_q.size() == 0) begin
          report_error($sformatf("unexpected result sum=%0d status=%0d",
                                 m_axis_tdata[SUM_WIDTH-1:0], m_axis_tuser));
        end else begin
          want = expected_sums_q.pop_front();
          if (m_axis_tdata[SUM_WIDTH-1:0] !== want.prime_sum)
            report_error($sformatf("result %0d prime_sum got %0d, expected %0d", result_count,
                                   m_axis_tdata[SUM_WIDTH-1:0], want.prime_sum));
          if (m_axis_tdata[OUT_DATA_W-1:SUM_WIDTH] !== '0)
            report_error($sformatf("result %0d pad bits got %0h", result_count,
                                   m_axis_tdata[OUT_DATA_W-1:SUM_WIDTH]));
          if (m_axis_tuser !== want.status)
            report_error($sformatf("result %0d status got %0d, expected %0d", result_count,
                                   m_axis_tuser, want.status));
        end
        result_count++;
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct[rx_phase]);
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_prime_range_sum_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus and end of run
  initial begin
    bound_t ra;
    bound_t rb;
    bound_t tmp;
    int     a;
    int     w;
    int     ph;
    int     i;

    // directed: field extremes, every status code, edge ranges
    add_bounds(-32768, 32767, 0, 1'b0);   // A most negative
    add_bounds(-32768, -32768, 0, 1'b0);  // both bits of status
    add_bounds(-1, -32768, 0, 1'b0);
    add_bounds(0, 0, 0, 1'b0);
    add_bounds(0, 10, 0, 1'b0);           // A zero
    add_bounds(32767, 32767, 0, 1'b0);    // A equals B
    add_bounds(32767, -32768, 0, 1'b0);
    add_bounds(5, 4, 0, 1'b0);
    add_bounds(1, 2, 0, 1'b0);            // empty range
    add_bounds(2, 3, 0, 1'b0);
    add_bounds(1, 3, 0, 1'b0);            // single prime, two
    add_bounds(12, 14, 0, 1'b0);          // single prime, thirteen
    add_bounds(7, 11, 0, 1'b0);           // candidates but no prime
    add_bounds(1, 100, 0, 1'b0);
    add_bounds(1, 200, 0, 1'b0);
    add_bounds(32765, 32767, 0, 1'b0);    // top of the valid range
    add_bounds(32740, 32767, 0, 1'b0);    // includes the largest prime
    add_bounds(32758, 32765, 0, 1'b0);    // composite with large smallest factor

    // random, phase by phase; first request of each phase waits for a drain
    for (ph = 0; ph < 4; ph++) begin
      for (i = 0; i < RAND_PER_PHASE; i++) begin
        if ($urandom_range(99) < 25) begin
          // noise: full-range bounds, forced invalid
          ra = bound_t'($urandom);
          rb = bound_t'($urandom);
          if (ra > 0 && ra < rb) begin
            tmp = ra;
            ra  = rb;
            rb  = tmp;
          end
          add_bounds(ra, rb, ph, i == 0);
        end else if ($urandom_range(99) < 85) begin
          a = $urandom_range(2000, 1);
          w = $urandom_range(32, 1);
          add_bounds(a, a + w, ph, i == 0);
        end else begin
          a = $urandom_range(32766, 1);
          w = $urandom_range(20, 1);
          add_bounds(a, (a + w > 32767) ? 32767 : a + w, ph, i == 0);
        end
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    wait (accepted_count == queued_count);
    wait (expected_sums_q.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("tb_prime_range_sum_top passed");
    end else begin
      $display("tb_prime_range_sum_top failed");
    end
    $finish;
  end

endmodule
